// ===== rtl/core/sbot_pkg.sv =====
`default_nettype none

package sbot_pkg;

    localparam int BUCKETS_PER_SKEW = 1024;
    localparam int WAYS_PER_SKEW    = 8;
    localparam int EXTRA_CAPACITY   = 2;
    localparam int SKEW_COUNT       = 2;
    localparam int NUM_LINES        = 16384;
    localparam int TOTAL_BUCKETS    = SKEW_COUNT * BUCKETS_PER_SKEW;

    localparam int SKEW_W   = $clog2(BUCKETS_PER_SKEW);
    localparam int BUCKET_W = $clog2(TOTAL_BUCKETS);
    localparam int LINE_W   = $clog2(NUM_LINES);
    localparam int COUNT_W  = 5;
    localparam int TOTAL_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
    localparam logic [COUNT_W-1:0] THRESH_RESET = COUNT_W'(WAYS_PER_SKEW + EXTRA_CAPACITY);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;

    typedef enum logic [1:0] {
        MODE_REMOVE = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_SPILL  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        STATUS_DONE    = 3'd0,
        STATUS_SPILL   = 3'd1,
        STATUS_CUCKOO  = 3'd2,
        STATUS_LINE    = 3'd3,
        STATUS_REFUSED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_LOC
    } state_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [LINE_W-1:0] ball_id;
        logic [9:0]        cand_skew0;
        logic [9:0]        cand_skew1;
        logic              tie_pick;
        logic [9:0]        spill_cand;
    } item_t;

    typedef struct packed {
        logic [10:0]        touched_bucket;
        logic [4:0]         count_before;
        logic [2:0]         status;
        logic [TOTAL_W-1:0] spill_total;
        logic [TOTAL_W-1:0] cuckoo_total;
    } result_t;

    typedef struct packed {
        logic                valid;
        logic [BUCKET_W-1:0] loc;
    } line_ent_t;

endpackage

`default_nettype wire

// ===== rtl/core/skewed_bucket_occupancy_tracker_top.sv =====
`default_nettype none

// Flow: an accepted item is evaluated in ST_EVAL, which registers done; a remove, or an
//   insert of a line already placed, goes on via ST_LOC (second bucket-count read).
// Issue: a new transaction is taken only while busy is low, after the last one leaves
//   ST_EVAL/ST_LOC (bucket-count read, then write). done is a one-cycle strobe; no stall.
// Reset: counters and spill state clear at once; a clearing pass then sweeps all 16384
//   line-map entries, and the 2048 bucket counts with the first of them, with busy high.
module skewed_bucket_occupancy_tracker_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sbot_pkg::item_t   item,
    output logic                   done,
    output sbot_pkg::result_t      result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [4:0]        cfg_data
);

    // memories
    logic [sbot_pkg::COUNT_W-1:0] bucket_mem [sbot_pkg::TOTAL_BUCKETS];
    sbot_pkg::line_ent_t          line_mem   [sbot_pkg::NUM_LINES];

    sbot_pkg::state_t                  state_reg, state_next;
    logic [sbot_pkg::LINE_W-1:0]       clr_reg, clr_next;
    sbot_pkg::item_t                   item_reg;
    logic [sbot_pkg::COUNT_W-1:0]      thresh_reg;
    logic                              pend_reg, pend_next;
    logic [sbot_pkg::LINE_W-1:0]       pline_reg, pline_next;
    logic                              pskew_reg, pskew_next;
    logic [sbot_pkg::TOTAL_W-1:0]      spills_reg, spills_next;
    logic [sbot_pkg::TOTAL_W-1:0]      cuckoo_reg, cuckoo_next;
    logic                              done_reg, done_next;
    sbot_pkg::result_t                 result_reg, result_next;

    logic                              accept;
    logic [sbot_pkg::BUCKET_W-1:0]     addr_a;
    logic [sbot_pkg::COUNT_W-1:0]      cnt_a_q, cnt_b_q;
    sbot_pkg::line_ent_t               line_q;
    logic                              rd_a_en;

    logic                              bwe;
    logic [sbot_pkg::BUCKET_W-1:0]     bwaddr;
    logic [sbot_pkg::COUNT_W-1:0]      bwdata;
    logic                              lwe;
    logic [sbot_pkg::LINE_W-1:0]       lwaddr;
    sbot_pkg::line_ent_t               lwdata;

    logic                              pick1;
    logic [sbot_pkg::BUCKET_W-1:0]     ins_b;
    logic [sbot_pkg::COUNT_W-1:0]      ins_cnt;
    logic [sbot_pkg::BUCKET_W-1:0]     sp_b;

    assign busy      = (state_reg != sbot_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    always_comb
    begin
        if (accept && (item.mode == sbot_pkg::MODE_SPILL))
        begin
            addr_a = {~pskew_reg, item.spill_cand[sbot_pkg::SKEW_W-1:0]};
        end
        else if (accept)
        begin
            addr_a = {1'b0, item.cand_skew0[sbot_pkg::SKEW_W-1:0]};
        end
        else
        begin
            addr_a = line_q.loc;
        end
        rd_a_en = accept || (state_reg == sbot_pkg::ST_EVAL);
    end

    always_ff @(posedge clk)
    begin
        if (rd_a_en)
        begin
            cnt_a_q <= bucket_mem[addr_a];
        end
        if (accept)
        begin
            cnt_b_q <= bucket_mem[{1'b1, item.cand_skew1[sbot_pkg::SKEW_W-1:0]}];
            line_q  <= line_mem[item.ball_id];
            item_reg <= item;
        end
        if (bwe)
        begin
            bucket_mem[bwaddr] <= bwdata;
        end
        if (lwe)
        begin
            line_mem[lwaddr] <= lwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sbot_pkg::ST_CLEAR;
            clr_reg    <= '0;
            thresh_reg <= sbot_pkg::THRESH_RESET;
            pend_reg   <= 1'b0;
            pline_reg  <= '0;
            pskew_reg  <= 1'b0;
            spills_reg <= '0;
            cuckoo_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            pend_reg   <= pend_next;
            pline_reg  <= pline_next;
            pskew_reg  <= pskew_next;
            spills_reg <= spills_next;
            cuckoo_reg <= cuckoo_next;
            done_reg   <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                thresh_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        pick1   = (cnt_b_q < cnt_a_q) || ((cnt_b_q == cnt_a_q) && item_reg.tie_pick);
        ins_b   = pick1 ? {1'b1, item_reg.cand_skew1[sbot_pkg::SKEW_W-1:0]}
                        : {1'b0, item_reg.cand_skew0[sbot_pkg::SKEW_W-1:0]};
        ins_cnt = pick1 ? cnt_b_q : cnt_a_q;
        sp_b    = {~pskew_reg, item_reg.spill_cand[sbot_pkg::SKEW_W-1:0]};
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pend_next   = pend_reg;
        pline_next  = pline_reg;
        pskew_next  = pskew_reg;
        spills_next = spills_reg;
        cuckoo_next = cuckoo_reg;
        done_next   = 1'b0;
        result_next = '0;
        bwe         = 1'b0;
        bwaddr      = ins_b;
        bwdata      = '0;
        lwe         = 1'b0;
        lwaddr      = item_reg.ball_id;
        lwdata      = '0;

        unique case (state_reg)
            sbot_pkg::ST_CLEAR:
            begin
                lwe    = 1'b1;
                lwaddr = clr_reg;
                bwe    = (clr_reg[sbot_pkg::LINE_W-1:sbot_pkg::BUCKET_W] == '0);
                bwaddr = clr_reg[sbot_pkg::BUCKET_W-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = sbot_pkg::ST_IDLE;
                end
            end
            sbot_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sbot_pkg::ST_EVAL;
                end
            end
            sbot_pkg::ST_EVAL:
            begin
                state_next = sbot_pkg::ST_IDLE;
                done_next  = 1'b1;
                result_next.status = sbot_pkg::STATUS_REFUSED;
                unique case (item_reg.mode)
                    sbot_pkg::MODE_REMOVE:
                    begin
                        if (!pend_reg && !line_q.valid)
                        begin
                            result_next.status = sbot_pkg::STATUS_LINE;
                        end
                        else if (!pend_reg)
                        begin
                            done_next  = 1'b0;
                            state_next = sbot_pkg::ST_LOC;
                        end
                    end
                    sbot_pkg::MODE_INSERT:
                    begin
                        if (!pend_reg && line_q.valid)
                        begin
                            done_next  = 1'b0;
                            state_next = sbot_pkg::ST_LOC;
                        end
                        else if (!pend_reg)
                        begin
                            result_next.touched_bucket = ins_b;
                            result_next.count_before = ins_cnt;
                            if ((thresh_reg != '0) && (ins_cnt >= thresh_reg))
                            begin
                                pend_next  = 1'b1;
                                pline_next = item_reg.ball_id;
                                pskew_next = pick1;
                                result_next.status = sbot_pkg::STATUS_SPILL;
                            end
                            else
                            begin
                                bwe    = 1'b1;
                                bwaddr = ins_b;
                                bwdata = (ins_cnt == sbot_pkg::COUNT_MAX) ? ins_cnt
                                                                          : ins_cnt + 1'b1;
                                lwe    = 1'b1;
                                lwaddr = item_reg.ball_id;
                                lwdata = '{valid: 1'b1, loc: ins_b};
                                result_next.status = sbot_pkg::STATUS_DONE;
                            end
                        end
                    end
                    sbot_pkg::MODE_SPILL:
                    begin
                        if (pend_reg)
                        begin
                            result_next.touched_bucket = sp_b;
                            result_next.count_before = cnt_a_q;
                            if ((thresh_reg == '0) || (cnt_a_q < thresh_reg))
                            begin
                                bwe    = 1'b1;
                                bwaddr = sp_b;
                                bwdata = (cnt_a_q == sbot_pkg::COUNT_MAX) ? cnt_a_q
                                                                          : cnt_a_q + 1'b1;
                                lwe    = 1'b1;
                                lwaddr = pline_reg;
                                lwdata = '{valid: 1'b1, loc: sp_b};
                                pend_next = 1'b0;
                                if (spills_reg != sbot_pkg::TOTAL_MAX)
                                begin
                                    spills_next = spills_reg + 1'b1;
                                end
                                result_next.status = sbot_pkg::STATUS_DONE;
                            end
                            else
                            begin
                                if (cuckoo_reg != sbot_pkg::TOTAL_MAX)
                                begin
                                    cuckoo_next = cuckoo_reg + 1'b1;
                                end
                                pskew_next = ~pskew_reg;
                                result_next.status = sbot_pkg::STATUS_CUCKOO;
                            end
                        end
                    end
                    default:
                    begin
                        result_next.status = sbot_pkg::STATUS_REFUSED;
                    end
                endcase
            end
            sbot_pkg::ST_LOC:
            begin
                state_next = sbot_pkg::ST_IDLE;
                done_next  = 1'b1;
                result_next.touched_bucket = line_q.loc;
                result_next.count_before = cnt_a_q;
                if (item_reg.mode == sbot_pkg::MODE_REMOVE)
                begin
                    bwe    = 1'b1;
                    bwaddr = line_q.loc;
                    bwdata = (cnt_a_q == '0) ? cnt_a_q : cnt_a_q - 1'b1;
                    lwe    = 1'b1;
                    lwaddr = item_reg.ball_id;
                    lwdata = '0;
                    result_next.status = sbot_pkg::STATUS_DONE;
                end
                else
                begin
                    result_next.status = sbot_pkg::STATUS_LINE;
                end
            end
            default:
            begin
                state_next = sbot_pkg::ST_CLEAR;
            end
        endcase

        result_next.spill_total  = spills_next;
        result_next.cuckoo_total = cuckoo_next;
    end

    a_done_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == sbot_pkg::ST_EVAL ||
                      $past(state_reg) == sbot_pkg::ST_LOC))
        else $error("result strobe without an item in evaluation");

    a_spill_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.status == sbot_pkg::STATUS_SPILL) |-> pend_reg)
        else $error("spill reported but no spill pending");

    a_spills_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        spills_reg >= $past(spills_reg))
        else $error("spill total went backwards");

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (bwe || lwe) |-> !accept)
        else $error("memory write coincides with a new transaction");

endmodule

`default_nettype wire
